[rtl/core/sbq_pkg.sv]
`timescale 1ns / 1ps
package sbq_pkg;

   localparam int BANDS          = 5;
   localparam int COEF_FRAC_BITS = 28;
   localparam int SAMPLE_BITS    = 16;

   localparam int NCOEF      = 5;
   localparam int SIG_W      = 32;
   localparam int COEF_W     = 32;
   localparam int DLY_W      = 48;
   localparam int PROD_W     = 64;
   localparam int ACC_W      = 50;
   localparam int GAIN_W     = 17;
   localparam int SIG_FRAC   = 28 - SAMPLE_BITS;
   localparam int PRE_SH     = 16 - SIG_FRAC;
   localparam int BAND_W     = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int COEF_IDX_W = $clog2(NCOEF * BANDS);
   localparam int PHASE_W    = 3;

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

   // input item kinds
   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_COEF  = 1'b1;

   // csr register indexes
   localparam logic CSR_GAIN   = 1'b0;
   localparam logic CSR_BYPASS = 1'b1;

   // section sequencer phases: one multiply issued per phase; the update phase product is unused
   localparam logic [PHASE_W-1:0] PH_B0  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_B1  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_B2  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_A1  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_A2  = 3'd4;
   localparam logic [PHASE_W-1:0] PH_UPD = 3'd5;

   typedef struct packed {
      logic               pre;
      logic               run;
      logic               clear;
      logic [PHASE_W-1:0] phase;
      logic [BAND_W-1:0]  band;
   } sbq_ctl_type;

   // product rounded half up back to signal format
   function automatic logic signed [ACC_W-1:0] rnd_prod(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = (p + (64'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      return t[ACC_W-1:0];
   endfunction

   function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = (ACC_W'(1) <<< (SIG_W - 1)) - ACC_W'(1);
      lo = -hi - ACC_W'(1);
      if (v > hi) return hi[SIG_W-1:0];
      if (v < lo) return lo[SIG_W-1:0];
      return v[SIG_W-1:0];
   endfunction

   function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = (ACC_W'(1) <<< (DLY_W - 1)) - ACC_W'(1);
      lo = -hi - ACC_W'(1);
      if (v > hi) return hi[DLY_W-1:0];
      if (v < lo) return lo[DLY_W-1:0];
      return v[DLY_W-1:0];
   endfunction

   // sample times gain, moved to signal format and saturated
   function automatic logic signed [SIG_W-1:0] pre_scale(input logic signed [SAMPLE_BITS-1:0] s,
                                                         input logic [GAIN_W-1:0] g);
      logic signed [PROD_W-1:0] v;
      v = PROD_W'(s) * $signed({{(PROD_W-GAIN_W){1'b0}}, g});
      if (PRE_SH > 0)
         v = (v + (64'sd1 <<< ((PRE_SH > 0) ? PRE_SH - 1 : 0))) >>> ((PRE_SH > 0) ? PRE_SH : 0);
      else
         v = v <<< ((PRE_SH < 0) ? -PRE_SH : 0);
      return sat_sig(v[ACC_W-1:0]);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] out_sample(input logic signed [SIG_W-1:0] x);
      logic signed [SIG_W:0] t;
      logic signed [SIG_W:0] hi;
      logic signed [SIG_W:0] lo;
      t  = ((SIG_W+1)'(x) + ((SIG_W+1)'(1) <<< (SIG_FRAC - 1))) >>> SIG_FRAC;
      hi = ((SIG_W+1)'(1) <<< (SAMPLE_BITS - 1)) - (SIG_W+1)'(1);
      lo = -hi - (SIG_W+1)'(1);
      if (t > hi) return hi[SAMPLE_BITS-1:0];
      if (t < lo) return lo[SAMPLE_BITS-1:0];
      return t[SAMPLE_BITS-1:0];
   endfunction

endpackage

[rtl/core/sbq_req_if.sv]
`timescale 1ns / 1ps
interface sbq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 kind;
   logic signed [sbq_pkg::SAMPLE_BITS-1:0] left_in;
   logic signed [sbq_pkg::SAMPLE_BITS-1:0] right_in;
   logic                                 last_in;
   logic [2:0]                           band_sel;
   logic [2:0]                           coef_sel;
   logic signed [31:0]                   coef_value;

   modport source (output valid, kind, left_in, right_in, last_in, band_sel, coef_sel,
                   coef_value, input ready);
   modport sink (input valid, kind, left_in, right_in, last_in, band_sel, coef_sel,
                 coef_value, output ready);
endinterface

[rtl/core/sbq_rsp_if.sv]
`timescale 1ns / 1ps
interface sbq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [sbq_pkg::SAMPLE_BITS-1:0] left_out;
   logic signed [sbq_pkg::SAMPLE_BITS-1:0] right_out;
   logic                                 last_out;

   modport source (output valid, left_out, right_out, last_out, input ready);
   modport sink (input valid, left_out, right_out, last_out, output ready);
endinterface

[rtl/core/sbq_coef.sv]
`timescale 1ns / 1ps
module sbq_coef (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [sbq_pkg::COEF_IDX_W-1:0]      wr_idx,
   input  logic signed [sbq_pkg::COEF_W-1:0]   wr_data,
   input  logic [sbq_pkg::COEF_IDX_W-1:0]      rd_idx,
   output logic signed [sbq_pkg::COEF_W-1:0]   rd_data
);
   import sbq_pkg::*;

   localparam int NENT = NCOEF * BANDS;

   logic signed [COEF_W-1:0] coef_ff [NENT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NENT; i++) begin
            coef_ff[i] <= ((i % NCOEF) == 0) ? (COEF_W'(1) <<< COEF_FRAC_BITS) : '0;
         end
      end else if (wr_en) begin
         coef_ff[wr_idx] <= wr_data;
      end
   end

   assign rd_data = coef_ff[rd_idx];
endmodule

[rtl/core/sbq_lane.sv]
`timescale 1ns / 1ps
module sbq_lane (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sbq_pkg::sbq_ctl_type                   ctl,
   input  logic signed [sbq_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [sbq_pkg::GAIN_W-1:0]             gain,
   input  logic signed [sbq_pkg::COEF_W-1:0]      coef,
   output logic signed [sbq_pkg::SAMPLE_BITS-1:0] result
);
   import sbq_pkg::*;

   logic signed [SIG_W-1:0]  x_ff;
   logic signed [SIG_W-1:0]  y_ff;
   logic signed [PROD_W-1:0] p_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc2_ff;
   logic signed [DLY_W-1:0]  d1_ff [BANDS];
   logic signed [DLY_W-1:0]  d2_ff [BANDS];

   logic signed [SIG_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] p_in;
   logic signed [ACC_W-1:0]  rp;

   // feedback coefficients multiply the section output
   assign mul_b = (ctl.phase == PH_A1 || ctl.phase == PH_A2) ? y_ff : x_ff;
   assign p_in  = PROD_W'(coef) * PROD_W'(mul_b);
   assign rp    = rnd_prod(p_ff);

   always_ff @(posedge clock) begin
      if (ctl.pre) begin
         x_ff <= pre_scale(sample, gain);
      end
      if (ctl.run) begin
         p_ff <= p_in;
         case (ctl.phase)
            PH_B1:  y_ff <= sat_sig(rp + ACC_W'(d1_ff[ctl.band]));
            PH_B2:  acc_ff <= rp + ACC_W'(d2_ff[ctl.band]);
            PH_A1:  acc2_ff <= rp;
            PH_A2:  acc_ff <= acc_ff - rp;
            PH_UPD: x_ff <= y_ff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         for (int i = 0; i < BANDS; i++) begin
            d1_ff[i] <= '0;
            d2_ff[i] <= '0;
         end
      end else if (ctl.run && ctl.phase == PH_UPD) begin
         d1_ff[ctl.band] <= sat_dly(acc_ff);
         d2_ff[ctl.band] <= sat_dly(acc2_ff - rp);
      end
   end

   assign result = out_sample(x_ff);
endmodule

[rtl/core/stereo_cascaded_biquad_equalizer.sv]
`timescale 1ns / 1ps
// a filtered frame passes the preamp state, the section phases of every band and the done state
// before it shows on rsp; the one multiplier in each lane does the five products of a section in turn,
// and a bypassed frame goes straight to the done state; a new frame is taken only once the last one
// has been moved into the response register; coefficient requests give no response
// reset (synchronous): bypass on, unity preamp, b0 = 1.0 in every section, delays zero
module stereo_cascaded_biquad_equalizer (
   input  logic                         clock,
   input  logic                         reset,
   sbq_req_if.sink                      req_ch,
   sbq_rsp_if.source                    rsp_ch,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [sbq_pkg::GAIN_W-1:0]   csr_wdata
);
   import sbq_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_PRE, S_RUN, S_DONE} state_type;

   state_type                      state_ff;
   logic [PHASE_W-1:0]             phase_ff;
   logic [BAND_W-1:0]              band_ff;
   logic                           byp_ff;
   logic signed [SAMPLE_BITS-1:0]  left_ff;
   logic signed [SAMPLE_BITS-1:0]  right_ff;
   logic                           last_ff;
   logic                           rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0]  rsp_left_ff;
   logic signed [SAMPLE_BITS-1:0]  rsp_right_ff;
   logic                           rsp_last_ff;
   logic [GAIN_W-1:0]              gain_ff;
   logic                           bypass_ff;

   logic                           req_fire;
   logic                           coef_ok;
   logic                           coef_we;
   logic [COEF_IDX_W-1:0]          wr_idx;
   logic [COEF_IDX_W-1:0]          rd_idx;
   logic signed [COEF_W-1:0]       coef;
   sbq_ctl_type                    ctl;
   logic signed [SAMPLE_BITS-1:0]  left_res;
   logic signed [SAMPLE_BITS-1:0]  right_res;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign coef_ok      = (int'(req_ch.band_sel) < BANDS) && (int'(req_ch.coef_sel) < NCOEF);
   assign coef_we      = req_fire && (req_ch.kind == KIND_COEF) && coef_ok;
   assign wr_idx       = COEF_IDX_W'(int'(req_ch.band_sel) * NCOEF + int'(req_ch.coef_sel));
   // update phase product is unused; point it at b0
   assign rd_idx       = COEF_IDX_W'(int'(band_ff) * NCOEF
                                     + ((phase_ff == PH_UPD) ? 0 : int'(phase_ff)));

   always_comb begin
      ctl.pre   = (state_ff == S_PRE);
      ctl.run   = (state_ff == S_RUN);
      ctl.clear = coef_we;
      ctl.phase = phase_ff;
      ctl.band  = band_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_RESET;
         bypass_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GAIN:   gain_ff <= csr_wdata;
            CSR_BYPASS: bypass_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   sbq_coef u_coef (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (coef_we),
      .wr_idx  (wr_idx),
      .wr_data (req_ch.coef_value),
      .rd_idx  (rd_idx),
      .rd_data (coef)
   );

   sbq_lane u_lane_left (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (left_ff),
      .gain   (gain_ff),
      .coef   (coef),
      .result (left_res)
   );

   sbq_lane u_lane_right (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (right_ff),
      .gain   (gain_ff),
      .coef   (coef),
      .result (right_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_B0;
         band_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire && req_ch.kind == KIND_FRAME) begin
                  left_ff  <= req_ch.left_in;
                  right_ff <= req_ch.right_in;
                  last_ff  <= req_ch.last_in;
                  byp_ff   <= bypass_ff;
                  state_ff <= bypass_ff ? S_DONE : S_PRE;
               end
            end
            S_PRE: begin
               phase_ff <= PH_B0;
               band_ff  <= '0;
               state_ff <= S_RUN;
            end
            S_RUN: begin
               if (phase_ff == PH_UPD) begin
                  phase_ff <= PH_B0;
                  if (int'(band_ff) == BANDS - 1) begin
                     state_ff <= S_DONE;
                  end else begin
                     band_ff <= band_ff + BAND_W'(1);
                  end
               end else begin
                  phase_ff <= phase_ff + PHASE_W'(1);
               end
            end
            S_DONE: begin
               // merge both lanes, or the raw samples when bypassed, into the response register once it is free
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_left_ff  <= byp_ff ? left_ff : left_res;
                  rsp_right_ff <= byp_ff ? right_ff : right_res;
                  rsp_last_ff  <= last_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.left_out  = rsp_left_ff;
   assign rsp_ch.right_out = rsp_right_ff;
   assign rsp_ch.last_out  = rsp_last_ff;

   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.kind == KIND_FRAME && !bypass_ff |=> state_ff == S_PRE)
      else $error("filter run did not start");

   a_coef_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.kind == KIND_COEF |=> state_ff == S_IDLE && !$rose(rsp_valid_ff))
      else $error("coefficient request produced work");

   a_band_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RUN |-> int'(band_ff) < BANDS)
      else $error("band counter out of range");
endmodule

[verif/sbq_eq_checker.sv]
`timescale 1ns / 1ps
module sbq_eq_checker (
   input  logic                       clock,
   input  logic                       reset,
   sbq_req_if                         req_mon,
   sbq_rsp_if                         rsp_mon,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [sbq_pkg::GAIN_W-1:0] csr_wdata,
   output int                         errors,
   output int                         outstanding,
   output int                         frames_seen
);
   import sbq_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
      logic                          last;
   } frame_out_type;

   frame_out_type     expected_frames[$];
   longint            coef_mem[NCOEF*BANDS];
   longint            z1_mem[2*BANDS];
   longint            z2_mem[2*BANDS];
   logic [GAIN_W-1:0] gain_reg;
   logic              bypass_reg;

   function automatic longint clamp(input longint v, input int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic longint round_shift(input longint v, input int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic longint coef_mul(input longint c, input longint s);
      return round_shift(c * s, COEF_FRAC_BITS);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] filter_lane(input logic signed [SAMPLE_BITS-1:0] s,
                                                          input int lane);
      longint x;
      longint y;
      int     d;
      x = longint'(s) * longint'(gain_reg);
      x = clamp(round_shift(x, 16 - SIG_FRAC), 32);
      for (int b = 0; b < BANDS; b++) begin
         d = b * 2 + lane;
         y = clamp(coef_mul(coef_mem[b*NCOEF], x) + z1_mem[d], 32);
         z1_mem[d] = clamp(coef_mul(coef_mem[b*NCOEF+1], x) - coef_mul(coef_mem[b*NCOEF+3], y)
                           + z2_mem[d], 48);
         z2_mem[d] = clamp(coef_mul(coef_mem[b*NCOEF+2], x) - coef_mul(coef_mem[b*NCOEF+4], y), 48);
         x = y;
      end
      return SAMPLE_BITS'(clamp(round_shift(x, SIG_FRAC), SAMPLE_BITS));
   endfunction

   assign outstanding = expected_frames.size();

   always @(posedge clock) begin
      frame_out_type got;
      frame_out_type want;
      if (reset) begin
         for (int i = 0; i < NCOEF*BANDS; i++)
            coef_mem[i] = (i % NCOEF == 0) ? (longint'(1) <<< COEF_FRAC_BITS) : 0;
         for (int i = 0; i < 2*BANDS; i++) begin
            z1_mem[i] = 0;
            z2_mem[i] = 0;
         end
         gain_reg = GAIN_RESET;
         bypass_reg = 1'b1;
         expected_frames.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_GAIN) gain_reg = csr_wdata;
            else bypass_reg = csr_wdata[0];
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = frame_out_type'{rsp_mon.left_out, rsp_mon.right_out, rsp_mon.last_out};
            if (expected_frames.size() == 0) begin
               $display("%0t: unexpected response %h/%h last %b", $time, got.left, got.right,
                        got.last);
               errors++;
            end else begin
               want = expected_frames.pop_front();
               frames_seen++;
               if (got.left !== want.left) begin
                  $display("%0t: left expected %h actual %h", $time, want.left, got.left);
                  errors++;
               end
               if (got.right !== want.right) begin
                  $display("%0t: right expected %h actual %h", $time, want.right, got.right);
                  errors++;
               end
               if (got.last !== want.last) begin
                  $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                  errors++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.kind == KIND_COEF) begin
               // bad section or coefficient select drops the request entirely
               if (req_mon.band_sel < BANDS && req_mon.coef_sel < NCOEF) begin
                  coef_mem[req_mon.band_sel*NCOEF + req_mon.coef_sel] = longint'(req_mon.coef_value);
                  for (int i = 0; i < 2*BANDS; i++) begin
                     z1_mem[i] = 0;
                     z2_mem[i] = 0;
                  end
               end
            end else if (bypass_reg) begin
               want = frame_out_type'{req_mon.left_in, req_mon.right_in, req_mon.last_in};
               expected_frames.push_back(want);
            end else begin
               want.left  = filter_lane(req_mon.left_in, 0);
               want.right = filter_lane(req_mon.right_in, 1);
               want.last  = req_mon.last_in;
               expected_frames.push_back(want);
            end
         end
      end
   end

   initial begin
      errors = 0;
      frames_seen = 0;
   end
endmodule

[verif/tb_stereo_cascaded_biquad_equalizer.sv]
`timescale 1ns / 1ps
module tb_stereo_cascaded_biquad_equalizer;
   import sbq_pkg::*;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic              csr_index;
   logic [GAIN_W-1:0] csr_wdata;
   int                errors;
   int                outstanding;
   int                frames_seen;
   bit                quiet;
   bit                hold_now;
   int                coef_writes;
   int                settings_run;

   sbq_req_if req_ch();
   sbq_rsp_if rsp_ch();

   stereo_cascaded_biquad_equalizer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sbq_eq_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .errors      (errors),
      .outstanding (outstanding),
      .frames_seen (frames_seen)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic send_request(input logic kind, input logic [15:0] left, input logic [15:0] right,
                               input logic last, input logic [2:0] band, input logic [2:0] sel,
                               input logic [31:0] value);
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= kind;
      req_ch.left_in    <= left;
      req_ch.right_in   <= right;
      req_ch.last_in    <= last;
      req_ch.band_sel   <= band;
      req_ch.coef_sel   <= sel;
      req_ch.coef_value <= value;
      if (kind == KIND_COEF) coef_writes++;
      do @(posedge clock); while (!req_ch.ready);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic send_frame(input logic [15:0] left, input logic [15:0] right);
      send_request(KIND_FRAME, left, right, 1'($urandom_range(0, 1)), 3'($urandom),
                   3'($urandom), $urandom);
   endtask

   task automatic send_coef(input int band, input int sel, input logic [31:0] value);
      send_request(KIND_COEF, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                   3'(band), 3'(sel), value);
   endtask

   // wait for every response, let a trailing coefficient request settle, then write
   task automatic write_settings(input logic [GAIN_W-1:0] gain, input logic bypass_on);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_we <= 1'b1; csr_index <= CSR_GAIN; csr_wdata <= gain;
      @(posedge clock);
      csr_index <= CSR_BYPASS; csr_wdata <= GAIN_W'(bypass_on);
      @(posedge clock);
      csr_we <= 1'b0;
      settings_run++;
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 64)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_request();
      int          band;
      int          sel;
      logic [31:0] value;
      if ($urandom_range(0, 12) != 0) begin
         send_frame(pick_sample(), pick_sample());
      end else if ($urandom_range(0, 5) == 0) begin
         // noise: wild values and selects that may be out of range
         send_coef($urandom_range(0, 7), $urandom_range(0, 7), $urandom);
      end else begin
         band = $urandom_range(0, BANDS - 1);
         sel  = $urandom_range(0, NCOEF - 1);
         if (sel == 3) value = 32'($urandom_range(0, 2**30)) - 32'(2**29);
         else if (sel == 4) value = 32'($urandom_range(0, 2**28)) - 32'(2**27);
         else value = 32'($urandom_range(0, 2**29)) - 32'(2**28);
         send_coef(band, sel, value);
      end
   endtask

   initial begin
      logic [GAIN_W-1:0] gains[7];
      logic              bypasses[7];
      reset = 1'b1;
      csr_we = 1'b0; csr_index = CSR_GAIN; csr_wdata = '0;
      req_ch.valid = 1'b0; req_ch.kind = KIND_FRAME; req_ch.left_in = '0; req_ch.right_in = '0;
      req_ch.last_in = 1'b0; req_ch.band_sel = '0; req_ch.coef_sel = '0; req_ch.coef_value = '0;
      quiet = 1'b0; hold_now = 1'b0; coef_writes = 0; settings_run = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset state is bypass; coefficient write there still lands
      send_frame(16'h7fff, 16'h8000);
      send_frame(16'h0000, 16'hffff);
      send_coef(0, 0, 32'h0800_0000);
      write_settings(GAIN_RESET, 1'b0);
      send_frame(16'h7fff, 16'h8000);
      send_frame(16'h0001, 16'hffff);
      send_frame(16'h0000, 16'h0000);
      for (int s = 0; s < NCOEF; s++) send_coef(BANDS - 1, s, 32'h0100_0000 >> s);
      send_coef(5, 0, 32'h7fff_ffff);
      send_coef(7, 7, 32'h8000_0000);
      send_coef(0, 5, 32'h7fff_ffff);
      send_frame(16'h7fff, 16'h8000);
      send_frame(16'h8000, 16'h7fff);
      send_coef(1, 1, 32'h7fff_ffff);
      send_coef(1, 3, 32'h8000_0000);
      send_frame(16'h7fff, 16'h8000);
      send_frame(16'h1234, 16'hedcb);
      write_settings(17'h1ffff, 1'b0);
      send_frame(16'h7fff, 16'h8000);
      send_frame(16'h4000, 16'hc000);
      write_settings(17'h0, 1'b0);
      send_frame(16'h7fff, 16'h8000);

      gains = '{17'h10000, 17'h1ffff, 17'h0, 17'h08000, 17'h10000, 17'h04000, 17'h0c000};
      bypasses = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
      for (int ph = 0; ph < 7; ph++) begin
         if (ph >= 5) gains[ph] = GAIN_W'($urandom_range(0, 131071));
         write_settings(gains[ph], bypasses[ph]);
         // back to a clean cascade so later phases start from sane filters
         for (int b = 0; b < BANDS; b++)
            for (int s = 0; s < NCOEF; s++) send_coef(b, s, (s == 0) ? 32'h1000_0000 : 32'h0);
         if (ph == 6) quiet = 1'b1;
         for (int i = 0; i < 150; i++) begin
            if (ph == 1 && i == 40) hold_now = 1'b1;
            random_request();
         end
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("covered %0d settings, %0d coefficient requests, %0d frames checked",
               settings_run, coef_writes, frames_seen);
      $display("gains from zero to above unity, bypass on and off, bad selects and long stalls");
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   // response side: random back-pressure plus one long hold-off
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         if (hold_now) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_now = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      #10ms;
      $display("timeout");
      $display("Some tests failed");
      $finish;
   end
endmodule

[sim.f]
rtl/core/sbq_pkg.sv
rtl/core/sbq_req_if.sv
rtl/core/sbq_rsp_if.sv
rtl/core/sbq_coef.sv
rtl/core/sbq_lane.sv
rtl/core/stereo_cascaded_biquad_equalizer.sv
verif/sbq_eq_checker.sv
verif/tb_stereo_cascaded_biquad_equalizer.sv
